@@ src/psd_pkg.sv @@
// Shared constants and types for the paired descending sorter.
package psd_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 24;
  localparam int PAYLOAD_BITS = 16;

  // Control phase: collecting a set, or draining it out.
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } psd_state_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;   // insert the incoming beat into the sorted chain
    logic shl;   // shift the chain toward cell 0 by one place
  } psd_cell_ctrl_t;

endpackage

@@ src/psd_channels.sv @@
// Valid/ready channel interfaces for the input pairs and the sorted results.
interface psd_in_if #(
  parameter int KEY_BITS = psd_pkg::KEY_BITS_DEF
);
  import psd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [KEY_BITS-1:0] key;
  logic [PAYLOAD_BITS-1:0]    payload;
  logic                       last;

  modport source (output valid, output key, output payload, output last, input ready);
  modport sink   (input valid, input key, input payload, input last, output ready);
endinterface

interface psd_out_if #(
  parameter int KEY_BITS = psd_pkg::KEY_BITS_DEF
);
  import psd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [KEY_BITS-1:0] sorted_key;
  logic [PAYLOAD_BITS-1:0]    sorted_payload;
  logic                       final_res;
  logic                       overflow;

  modport source (output valid, output sorted_key, output sorted_payload,
                  output final_res, output overflow, input ready);
  modport sink   (input valid, input sorted_key, input sorted_payload,
                  input final_res, input overflow, output ready);
endinterface

@@ src/psd_cell.sv @@
// One cell of the insertion chain: holds a key/payload pair and its neighbor moves.
module psd_cell #(
  parameter int KEY_BITS = psd_pkg::KEY_BITS_DEF
) (
  input  logic                              clk,
  input  psd_pkg::psd_cell_ctrl_t           ctrl,
  input  logic                              occupied,
  input  logic signed [KEY_BITS-1:0]        new_key,
  input  logic [psd_pkg::PAYLOAD_BITS-1:0]  new_payload,
  input  logic                              left_take,
  input  logic signed [KEY_BITS-1:0]        left_key,
  input  logic [psd_pkg::PAYLOAD_BITS-1:0]  left_payload,
  input  logic signed [KEY_BITS-1:0]        right_key,
  input  logic [psd_pkg::PAYLOAD_BITS-1:0]  right_payload,
  output logic                              take,
  output logic signed [KEY_BITS-1:0]        key,
  output logic [psd_pkg::PAYLOAD_BITS-1:0]  payload
);
  import psd_pkg::*;

  logic signed [KEY_BITS-1:0] key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0]    pay_r, pay_nxt;

  // The new key lands in front of the first strictly smaller key, so equal
  // keys keep their arrival order.
  assign take = !occupied || (key_r < new_key);

  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    if (ctrl.shl) begin
      key_nxt = right_key;
      pay_nxt = right_payload;
    end else if (ctrl.ins) begin
      if (left_take) begin
        key_nxt = left_key;
        pay_nxt = left_payload;
      end else if (take) begin
        key_nxt = new_key;
        pay_nxt = new_payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign key     = key_r;
  assign payload = pay_r;

endmodule

@@ src/paired_descending_sort_top.sv @@
// Top level of the stable descending sorter for key/payload pairs.
// The block collects a set of key/payload beats on in_bus, one beat per clock,
// and keeps them sorted as they arrive in a chain of DEPTH cells: each new key
// is compared against every stored key at once and slides in ahead of the
// first strictly smaller one, the cells behind it moving one place down. Equal
// keys therefore keep their arrival order. The beat flagged last closes the
// set; from the next cycle on the chain drains out of cell 0, one result per
// clock while out_bus is not stalled, largest key first, through an output
// register on out_bus. Input is accepted while a set is being collected and is
// held off while a set drains; the drain rate is set by the single output
// register feeding from cell 0.
// The next set may start as soon as the final result is in the output
// register, even if the sink has not taken it yet. Beats beyond DEPTH in one
// set are discarded, and every result of that set then carries overflow = 1.
// final_res marks the last result of each set. There is no clearing pass
// after reset; the block is ready in the first cycle after rst_n rises.
module paired_descending_sort_top #(
  parameter int DEPTH    = psd_pkg::DEPTH_DEF,
  parameter int KEY_BITS = psd_pkg::KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  psd_in_if.sink    in_bus,
  psd_out_if.source out_bus
);
  import psd_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Control state.
  psd_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic            dropped_r, dropped_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic signed [KEY_BITS-1:0] out_key_r;
  logic [PAYLOAD_BITS-1:0]    out_pay_r;
  logic                       out_final_r;
  logic                       out_ovf_r;

  // Handshake and chain commands.
  logic           in_ready;
  logic           accept;
  logic           full;
  logic           load;
  logic           last_one;
  psd_cell_ctrl_t cell_ctrl;

  // Chain taps.
  logic signed [KEY_BITS-1:0] cell_key  [DEPTH];
  logic [PAYLOAD_BITS-1:0]    cell_pay  [DEPTH];
  logic                       cell_take [DEPTH];

  assign accept   = in_bus.valid && in_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign last_one = (count_r == CNT_W'(1));

  // A beat that finds the chain full is discarded but may still close the set.
  assign cell_ctrl.ins = accept && !full;
  assign cell_ctrl.shl = load;

  // Next phase.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL: begin
        if (accept && in_bus.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (load && last_one) begin
          state_nxt = ST_FILL;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  // Phase outputs: accept beats while filling, move results while draining
  // whenever the output register is free or being emptied.
  always_comb begin
    in_ready = 1'b0;
    load     = 1'b0;
    case (state_r)
      ST_FILL: begin
        in_ready = 1'b1;
      end
      ST_DRAIN: begin
        load = !out_valid_r || out_bus.ready;
      end
      default: begin
        in_ready = 1'b0;
        load     = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cell_ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (load) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    dropped_nxt = dropped_r;
    if (accept && full) begin
      dropped_nxt = 1'b1;
    end else if (load && last_one) begin
      dropped_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result data: cell 0 always holds the largest remaining key.
  always_ff @(posedge clk) begin
    if (load) begin
      out_key_r   <= cell_key[0];
      out_pay_r   <= cell_pay[0];
      out_final_r <= last_one;
      out_ovf_r   <= dropped_r;
    end
  end

  // The chain. Cell i is occupied while i is below the fill count, so the
  // stored keys always sit sorted in cells 0 to count_r - 1.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                       occupied;
    logic                       left_take;
    logic signed [KEY_BITS-1:0] left_key;
    logic [PAYLOAD_BITS-1:0]    left_pay;
    logic signed [KEY_BITS-1:0] right_key;
    logic [PAYLOAD_BITS-1:0]    right_pay;

    assign occupied = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_take = 1'b0;
      assign left_key  = in_bus.key;
      assign left_pay  = in_bus.payload;
    end else begin : g_body
      assign left_take = cell_take[i-1];
      assign left_key  = cell_key[i-1];
      assign left_pay  = cell_pay[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // The tail cell becomes unoccupied on a shift; its contents do not matter.
      assign right_key = cell_key[i];
      assign right_pay = cell_pay[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
      assign right_pay = cell_pay[i+1];
    end

    psd_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk           (clk),
      .ctrl          (cell_ctrl),
      .occupied      (occupied),
      .new_key       (in_bus.key),
      .new_payload   (in_bus.payload),
      .left_take     (left_take),
      .left_key      (left_key),
      .left_payload  (left_pay),
      .right_key     (right_key),
      .right_payload (right_pay),
      .take          (cell_take[i]),
      .key           (cell_key[i]),
      .payload       (cell_pay[i])
    );
  end

  assign in_bus.ready           = in_ready;
  assign out_bus.valid          = out_valid_r;
  assign out_bus.sorted_key     = out_key_r;
  assign out_bus.sorted_payload = out_pay_r;
  assign out_bus.final_res      = out_final_r;
  assign out_bus.overflow       = out_ovf_r;

endmodule

@@ test/paired_descending_sort_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the paired descending sorter, with a random driver and a checking monitor.
module paired_descending_sort_top_tb;
  import psd_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int KEY_BITS     = KEY_BITS_DEF;
  localparam int RANDOM_PAIRS = 85;
  // Cycles without any accepted beat on either side before the run is declared hung.
  localparam int STALL_LIMIT  = 1000;
  // Extra run after the last expected result, to catch any stray late result.
  localparam int TAIL_CYCLES  = 2 * DEPTH + 8;
  localparam int REPORT_LIMIT = 10;

  typedef logic signed [KEY_BITS-1:0] key_t;

  typedef struct packed {
    key_t                    key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    last;
  } pair_t;

  typedef struct packed {
    key_t                    key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    final_res;
    logic                    overflow;
  } rank_t;

  localparam key_t KEY_MAX = key_t'((1 << (KEY_BITS - 1)) - 1);
  localparam key_t KEY_MIN = key_t'(1 << (KEY_BITS - 1));

  logic clk = 1'b0;
  logic rst_n;

  psd_in_if  #(.KEY_BITS(KEY_BITS)) in_bus ();
  psd_out_if #(.KEY_BITS(KEY_BITS)) out_bus ();

  paired_descending_sort_top #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #1 clk = ~clk;

  // Beats waiting to be driven, and sorted results the block still owes us.
  pair_t pending_pairs[$];
  rank_t sorted_expect[$];

  // Private copy of the set being collected, mirroring the block's store.
  key_t                    set_keys[DEPTH];
  logic [PAYLOAD_BITS-1:0] set_payloads[DEPTH];
  int                      set_fill;
  logic                    set_dropped;

  int accepted_pairs;
  int checked_ranks;
  int error_count;
  int quiet_cycles;

  // A stretch in the middle of the run where neither side ever pauses, so
  // the block also sees back-to-back beats and an unthrottled drain.
  logic steady;
  assign steady = (accepted_pairs >= 50) && (accepted_pairs < 80);

  task automatic queue_pair(key_t k, logic [PAYLOAD_BITS-1:0] p, logic l);
    pair_t beat;
    beat.key     = k;
    beat.payload = p;
    beat.last    = l;
    pending_pairs.push_back(beat);
  endtask

  // Narrow keys produce plenty of ties, which is where stability shows up.
  function automatic key_t pick_key(bit narrow);
    if (narrow) begin
      return key_t'(int'($urandom_range(6)) - 3);
    end
    case ($urandom_range(15))
      0:       return KEY_MAX;
      1:       return KEY_MIN;
      default: return key_t'($urandom());
    endcase
  endfunction

  // One well-formed set: mostly partial sets, some exactly full, some that
  // spill past the store so the overflow flag gets exercised.
  task automatic queue_random_set();
    int  count;
    int  i;
    bit  narrow;
    case ($urandom_range(9))
      0:       count = DEPTH;
      1:       count = DEPTH + 1 + $urandom_range(2);
      default: count = 1 + $urandom_range(DEPTH - 2);
    endcase
    narrow = ($urandom_range(2) == 0);
    for (i = 0; i < count; i++) begin
      queue_pair(pick_key(narrow), PAYLOAD_BITS'($urandom()), i == count - 1);
    end
  endtask

  // Absorbs one accepted beat. On the closing beat the stored set is ranked
  // with a stable insertion sort (an entry only passes strictly smaller keys)
  // and the whole ranking is appended to the expected results.
  task automatic absorb_pair(pair_t beat);
    key_t                    ranked_key[DEPTH];
    logic [PAYLOAD_BITS-1:0] ranked_payload[DEPTH];
    rank_t                   res;
    int                      i;
    int                      j;
    if (set_fill < DEPTH) begin
      set_keys[set_fill]     = beat.key;
      set_payloads[set_fill] = beat.payload;
      set_fill++;
    end else begin
      set_dropped = 1'b1;
    end
    if (beat.last) begin
      for (i = 0; i < set_fill; i++) begin
        j = i;
        while (j > 0 && ranked_key[j-1] < set_keys[i]) begin
          ranked_key[j]     = ranked_key[j-1];
          ranked_payload[j] = ranked_payload[j-1];
          j--;
        end
        ranked_key[j]     = set_keys[i];
        ranked_payload[j] = set_payloads[i];
      end
      for (i = 0; i < set_fill; i++) begin
        res.key       = ranked_key[i];
        res.payload   = ranked_payload[i];
        res.final_res = (i == set_fill - 1);
        res.overflow  = set_dropped;
        sorted_expect.push_back(res);
      end
      set_fill    = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic check_rank(rank_t got);
    rank_t want;
    if (sorted_expect.size() == 0) begin
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
        $display("result %0d: unexpected beat key %0d payload %0h final %0b overflow %0b",
                 checked_ranks, got.key, got.payload, got.final_res, got.overflow);
      end
    end else begin
      want = sorted_expect.pop_front();
      if (got !== want) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("result %0d: expected key %0d payload %0h final %0b overflow %0b",
                   checked_ranks, want.key, want.payload, want.final_res, want.overflow);
          $display("result %0d: got      key %0d payload %0h final %0b overflow %0b",
                   checked_ranks, got.key, got.payload, got.final_res, got.overflow);
        end
      end
    end
    checked_ranks++;
  endtask

  // Driver: a new beat is only put up once the previous one has been taken,
  // so valid never drops while a beat is on offer.
  pair_t drive_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (pending_pairs.size() > 0 && (steady || $urandom_range(99) >= 17)) begin
        drive_beat = pending_pairs.pop_front();
        in_bus.valid   <= 1'b1;
        in_bus.key     <= drive_beat.key;
        in_bus.payload <= drive_beat.payload;
        in_bus.last    <= drive_beat.last;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor: samples both channels at the edge where the handshake happens.
  // Results are checked before the input beat is absorbed; a beat can only
  // cause results in later cycles, so the order does not matter for timing.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= steady || ($urandom_range(99) >= 17);
      if (out_bus.valid && out_bus.ready) begin
        check_rank('{out_bus.sorted_key, out_bus.sorted_payload,
                     out_bus.final_res, out_bus.overflow});
      end
      if (in_bus.valid && in_bus.ready) begin
        absorb_pair('{in_bus.key, in_bus.payload, in_bus.last});
        accepted_pairs++;
      end
    end
  end

  // Watchdog: any accepted beat on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < STALL_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    set_fill       = 0;
    set_dropped    = 1'b0;
    accepted_pairs = 0;
    checked_ranks  = 0;
    error_count    = 0;

    // Single-beat sets at both key extremes and both payload extremes.
    queue_pair(KEY_MAX, '1, 1'b1);
    queue_pair(KEY_MIN, '0, 1'b1);

    // Ties around zero: equal keys must come out in arrival order.
    queue_pair(key_t'(0),  16'h0001, 1'b0);
    queue_pair(key_t'(-1), 16'h0002, 1'b0);
    queue_pair(key_t'(0),  16'h0003, 1'b0);
    queue_pair(key_t'(-1), 16'h0004, 1'b0);
    queue_pair(key_t'(0),  16'h0005, 1'b1);

    // A set two beats longer than the store: both extra beats are dropped,
    // the second one still closes the set, and every result flags overflow.
    for (int i = 0; i < DEPTH + 2; i++) begin
      queue_pair(pick_key(1'b1), PAYLOAD_BITS'(16'h0100 + i), i == DEPTH + 1);
    end

    while (pending_pairs.size() < 25 + RANDOM_PAIRS) begin
      queue_random_set();
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() != 0 || in_bus.valid || sorted_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && sorted_expect.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
